[rtl/core/tfbe_pkg.sv]
// Shared types and constants for the typed field byte encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package tfbe_pkg;

	// Input opcodes
	typedef enum logic [2:0] {
		OP_INT32  = 3'd0,
		OP_INT64  = 3'd1,
		OP_FLOAT  = 3'd2,
		OP_BOOL   = 3'd3,
		OP_LENGTH = 3'd4
	} op_t;

	localparam int VALUE_W     = 64;
	localparam int BYTE_W      = 8;
	localparam int VARINT_BITS = 7;   // payload bits per varint byte (0x7f mask)
	localparam int CNT_W       = 3;   // fixed-width byte count, up to 4
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CNT_W-1:0] FIXED32_BYTES = 3'd4;
	localparam logic [CNT_W-1:0] SINGLE_BYTE   = 3'd1;

	// One serialization command passed from front to back
	typedef struct packed {
		logic                varint;  // 1: base-128 varint, 0: fixed byte count
		logic [CNT_W-1:0]    nbytes;  // fixed mode only
		logic [VALUE_W-1:0]  data;
	} cmd_t;

endpackage

`default_nettype wire

[rtl/core/tfbe_front.sv]
// Front end: accepts input words, classifies the opcode and builds a command.
// Depends on tfbe_pkg.
`default_nettype none

module tfbe_front (
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [2:0]                    opcode,
	input  wire logic signed [tfbe_pkg::VALUE_W-1:0] value,
	input  wire logic                          q_full,
	output logic                               q_wr,
	output tfbe_pkg::cmd_t                     q_cmd
);

	logic [tfbe_pkg::VALUE_W-1:0] src;
	logic                         valid_op;

	assign full = q_full;

	// Opcode decode and zigzag mapping
	always_comb begin
		src      = '0;
		valid_op = 1'b1;
		q_cmd    = '0;
		case (tfbe_pkg::op_t'(opcode))
			tfbe_pkg::OP_INT32: begin
				src          = {{32{value[31]}}, value[31:0]};
				q_cmd.varint = 1'b1;
				q_cmd.data   = {src[62:0], 1'b0} ^ {64{src[63]}};
			end
			tfbe_pkg::OP_INT64: begin
				src          = value;
				q_cmd.varint = 1'b1;
				q_cmd.data   = {src[62:0], 1'b0} ^ {64{src[63]}};
			end
			tfbe_pkg::OP_FLOAT, tfbe_pkg::OP_LENGTH: begin
				q_cmd.nbytes = tfbe_pkg::FIXED32_BYTES;
				q_cmd.data   = {32'd0, value[31:0]};
			end
			tfbe_pkg::OP_BOOL: begin
				q_cmd.nbytes = tfbe_pkg::SINGLE_BYTE;
				q_cmd.data   = {63'd0, (value != '0)};
			end
			default: begin
				valid_op = 1'b0;   // unused opcodes are accepted and dropped
			end
		endcase
	end

	assign q_wr = push && !q_full && valid_op;

endmodule

`default_nettype wire

[rtl/core/tfbe_queue.sv]
// Small command queue between front and back ends.
// Depends on tfbe_pkg for the command type.
`default_nettype none

module tfbe_queue #(
	parameter int Depth = tfbe_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  wire tfbe_pkg::cmd_t wr_cmd,
	output logic                q_full,
	input  wire logic           rd,
	output logic                q_empty,
	output tfbe_pkg::cmd_t      rd_cmd
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	tfbe_pkg::cmd_t   mem_q [Depth];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign q_full  = (count_q == CW'(Depth));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_cmd  = mem_q[rptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
	endfunction

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= next_ptr(wptr_q);
			if (do_rd) rptr_q <= next_ptr(rptr_q);
			if (do_wr && !do_rd) count_q <= count_q + CW'(1);
			else if (!do_wr && do_rd) count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

[rtl/core/tfbe_back.sv]
// Back end: serializes queued commands into bytes, one per cycle unless a low pop
// stalls the output, into a registered output byte. Depends on tfbe_pkg.
`default_nettype none

module tfbe_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire tfbe_pkg::cmd_t q_cmd,
	output logic                q_rd,
	output logic                empty,
	input  wire logic           pop,
	output logic [tfbe_pkg::BYTE_W-1:0] out_byte,
	output logic                last
);

	localparam int VB = tfbe_pkg::VARINT_BITS;
	localparam int VW = tfbe_pkg::VALUE_W;

	tfbe_pkg::cmd_t             work_q;
	logic                       busy_q;
	logic                       out_valid_q;
	logic [tfbe_pkg::BYTE_W-1:0] byte_q;
	logic                       last_q;

	tfbe_pkg::cmd_t             src;
	tfbe_pkg::cmd_t             nxt;
	logic                       take, have, src_last;
	logic [VW-VB-1:0]           rest;
	logic [tfbe_pkg::BYTE_W-1:0] src_byte;

	assign take  = !out_valid_q || pop;
	assign have  = busy_q || !q_empty;
	assign src   = busy_q ? work_q : q_cmd;
	assign q_rd  = take && !busy_q && !q_empty;
	assign rest  = src.data[VW-1:VB];

	// Next byte from the current command
	always_comb begin
		nxt = src;
		if (src.varint) begin
			src_byte = {(rest != '0), src.data[VB-1:0]};
			src_last = (rest == '0);
			nxt.data = {{VB{1'b0}}, rest};
		end else begin
			src_byte   = src.data[tfbe_pkg::BYTE_W-1:0];
			src_last   = (src.nbytes == tfbe_pkg::SINGLE_BYTE);
			nxt.data   = src.data >> tfbe_pkg::BYTE_W;
			nxt.nbytes = src.nbytes - tfbe_pkg::CNT_W'(1);
		end
	end

	// Working command, not reset
	always_ff @(posedge clk) begin
		if (take && have) begin
			work_q <= nxt;
			byte_q <= src_byte;
			last_q <= src_last;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= have;
			if (have) busy_q <= !src_last;
		end
	end

	assign empty    = !out_valid_q;
	assign out_byte = byte_q;
	assign last     = last_q;

endmodule

`default_nettype wire

[rtl/core/typed_field_byte_encoder.sv]
// Top level of the typed field byte encoder: front, command queue and back.
// Depends on tfbe_pkg, tfbe_front, tfbe_queue and tfbe_back.
//
// Usage:
//   Input side is a queue write port: opcode and value are taken at a rising
//   edge with push high and full low. Opcode 0/1 give zigzag varints (int32
//   sign-extends the low 32 bits), 2 and 4 give four little-endian bytes of
//   the low 32 bits, 3 gives one byte 0 or 1. Opcodes 5..7 are taken and
//   produce nothing.
//   Output side is a queue read port: while empty is low, out_byte and last
//   hold the oldest byte; it leaves at a rising edge with pop high.
//   With the back end idle, the first byte of an accepted word passes through
//   the command queue and is then registered in the back end output byte.
//   The back end emits one byte per cycle while pop keeps up with it; a word
//   has 1 to 10 bytes (varint), 4 or 1 otherwise.
//   The command queue (QueueDepth entries) lets the input keep taking words
//   while the back end serializes; full rises once it fills.
//   When pop stays low the output byte holds and the back end stops;
//   the queue then fills and full backs up the input.
//   Reset clears the queue and output valid; no words are pending after it.
`default_nettype none

module typed_field_byte_encoder #(
	parameter int QueueDepth = tfbe_pkg::QUEUE_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [2:0]                         opcode,
	input  wire logic signed [tfbe_pkg::VALUE_W-1:0] value,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic [tfbe_pkg::BYTE_W-1:0]             out_byte,
	output logic                                    last
);

	tfbe_pkg::cmd_t wr_cmd, rd_cmd;
	logic           q_wr, q_full, q_rd, q_empty;

	// Accept and classify
	tfbe_front u_front (
		.push   (push),
		.full   (full),
		.opcode (opcode),
		.value  (value),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_cmd  (wr_cmd)
	);

	// Decoupling queue
	tfbe_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_cmd  (wr_cmd),
		.q_full  (q_full),
		.rd      (q_rd),
		.q_empty (q_empty),
		.rd_cmd  (rd_cmd)
	);

	// Serialize
	tfbe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_cmd    (rd_cmd),
		.q_rd     (q_rd),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule

`default_nettype wire

[tb/sv/tb_typed_field_byte_encoder.sv]
// Self-checking testbench for typed_field_byte_encoder: varint, fixed and bool serialization.
// Depends on tfbe_pkg and the typed_field_byte_encoder RTL; nothing else is read.
`timescale 1ns / 1ps

module tb_typed_field_byte_encoder;

	localparam int RUN_LIMIT   = 200000;  // cycles before the run is declared hung
	localparam int DRAIN_SLACK = 20;      // cycles to watch for stray bytes at the end

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} enc_byte_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic [2:0]          opcode = 3'd0;
	logic signed [63:0]  value = 64'sd0;
	logic                pop = 1'b0;
	wire                 full;
	wire                 empty;
	wire [7:0]           out_byte;
	wire                 last;

	enc_byte_t pending_bytes[$];   // bytes the encoder still owes, oldest first
	int        mismatches = 0;
	int        send_idle_pct = 0;  // chance per cycle that the sender holds off
	int        recv_idle_pct = 0;  // chance per cycle that pop stays low

	typed_field_byte_encoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.opcode   (opcode),
		.value    (value),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.last     (last)
	);

	always #1 clk = ~clk;

	// Byte stream that one accepted word must produce
	function automatic void serialize_word(input logic [2:0] op, input logic [63:0] val);
		logic [63:0] ext;
		logic [63:0] zz;
		enc_byte_t   eb;
		case (op)
			tfbe_pkg::OP_INT32, tfbe_pkg::OP_INT64: begin
				// int32 ignores the upper half and sign-extends bit 31
				ext = (op == tfbe_pkg::OP_INT32) ? {{32{val[31]}}, val[31:0]} : val;
				zz  = {ext[62:0], 1'b0} ^ {64{ext[63]}};
				do begin
					eb.data = {1'b0, zz[6:0]};
					zz = zz >> 7;
					eb.data[7] = (zz != 64'd0);
					eb.fin     = (zz == 64'd0);
					pending_bytes.push_back(eb);
				end while (zz != 64'd0);
			end
			tfbe_pkg::OP_FLOAT, tfbe_pkg::OP_LENGTH: begin
				for (int i = 0; i < 4; i++) begin
					eb.data = val[8*i +: 8];
					eb.fin  = (i == 3);
					pending_bytes.push_back(eb);
				end
			end
			tfbe_pkg::OP_BOOL: begin
				eb.data = (val != 64'd0) ? 8'h01 : 8'h00;
				eb.fin  = 1'b1;
				pending_bytes.push_back(eb);
			end
			default: ;  // unused opcodes are swallowed
		endcase
	endfunction

	// Value spread: full-width, shifted down for every varint length, and small
	function automatic logic signed [63:0] random_value();
		logic signed [63:0] r;
		int                 k;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return r;
			1: return r >>> $urandom_range(0, 63);
			2: return r >> $urandom_range(0, 63);
			default: begin
				k = $urandom_range(0, 300);
				k = k - 150;
				return 64'(k);
			end
		endcase
	endfunction

	// Offer one word and hold it until the encoder takes it
	task automatic send_word(input logic [2:0] op, input logic signed [63:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push   <= 1'b1;
		opcode <= op;
		value  <= val;
		do @(posedge clk); while (full);
		serialize_word(op, val);
	endtask

	task automatic stop_push();
		push <= 1'b0;
		@(posedge clk);
	endtask

	// Sender holds off until every owed byte has come out
	task automatic wait_drained();
		stop_push();
		while (pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Byte-wise check of everything popped
	always @(posedge clk) begin
		enc_byte_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pending_bytes.size() == 0) begin
					$error("unexpected word: out_byte %h last %b", out_byte, last);
					mismatches++;
				end else begin
					want = pending_bytes.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %h, actual %h", want.data, out_byte);
						mismatches++;
					end
					if (last !== want.fin) begin
						$error("last: expected %b, actual %b", want.fin, last);
						mismatches++;
					end
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Zigzag boundaries, sign extension and the 10-byte codes
	task automatic test_varint_edges();
		send_word(tfbe_pkg::OP_INT32, 64'sd0);
		send_word(tfbe_pkg::OP_INT32, 64'sd63);
		send_word(tfbe_pkg::OP_INT32, 64'sd64);
		send_word(tfbe_pkg::OP_INT32, -64'sd1);
		send_word(tfbe_pkg::OP_INT32, 64'sh5555_5555_7fff_ffff);
		send_word(tfbe_pkg::OP_INT32, 64'shdead_beef_8000_0000);
		send_word(tfbe_pkg::OP_INT64, 64'sd0);
		send_word(tfbe_pkg::OP_INT64, -64'sd1);
		send_word(tfbe_pkg::OP_INT64, 64'sh7fff_ffff_ffff_ffff);
		send_word(tfbe_pkg::OP_INT64, 64'sh8000_0000_0000_0000);
		send_word(tfbe_pkg::OP_INT64, 64'sh4000_0000_0000_0000);
		stop_push();
	endtask

	// Fixed 4-byte words and bool, including high-bit-only nonzero
	task automatic test_fixed_and_bool();
		send_word(tfbe_pkg::OP_FLOAT, 64'shffff_ffff_3f80_0000);
		send_word(tfbe_pkg::OP_FLOAT, 64'sh0000_0000_8000_0001);
		send_word(tfbe_pkg::OP_LENGTH, 64'sh0123_4567_89ab_cdef);
		send_word(tfbe_pkg::OP_LENGTH, 64'sd0);
		send_word(tfbe_pkg::OP_BOOL, 64'sd0);
		send_word(tfbe_pkg::OP_BOOL, 64'sd1);
		send_word(tfbe_pkg::OP_BOOL, 64'sh8000_0000_0000_0000);
		send_word(tfbe_pkg::OP_BOOL, -64'sd1);
		stop_push();
	endtask

	// Opcodes past the last encoding must produce no bytes
	task automatic test_unused_opcodes();
		send_word(3'd5, -64'sd1);
		send_word(3'd6, 64'sh0123_4567_89ab_cdef);
		send_word(3'd7, 64'sd0);
		send_word(tfbe_pkg::OP_BOOL, 64'sd1);
		stop_push();
	endtask

	// Random words; unused opcodes are mixed in but not counted
	task automatic test_random_words(input int n_words, input int send_pct, input int recv_pct);
		int          sent;
		logic [2:0]  op;
		sent = 0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (sent < n_words) begin
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
			                                  : 3'($urandom_range(0, 4));
			send_word(op, random_value());
			if (op <= tfbe_pkg::OP_LENGTH)
				sent++;
		end
		stop_push();
	endtask

	// Hang guard
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 51;
		test_varint_edges();
		test_fixed_and_bool();
		test_unused_opcodes();
		wait_drained();

		test_random_words(123, 25, 51);
		wait_drained();
		test_random_words(123, 51, 25);
		wait_drained();
		test_random_words(123, 0, 0);

		wait_drained();
		repeat (DRAIN_SLACK) @(posedge clk);
		if (mismatches == 0 && pending_bytes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[typed_field_byte_encoder.f]
rtl/core/tfbe_pkg.sv
rtl/core/tfbe_front.sv
rtl/core/tfbe_queue.sv
rtl/core/tfbe_back.sv
rtl/core/typed_field_byte_encoder.sv
tb/sv/tb_typed_field_byte_encoder.sv
